// ----- src/hps_pkg.sv -----
// Shared types and constants for the host power sequencer.
package hps_pkg;

  localparam int TimeWidth  = 32;
  localparam int CountWidth = 10;
  localparam int AddrWidth  = 4;
  localparam int DataWidth  = 32;

  localparam logic [CountWidth-1:0] COUNT_MAX = '1;

  localparam logic [TimeWidth-1:0]  ALIVE_INTERVAL_RESET    = 32'd5000;
  localparam logic [TimeWidth-1:0]  SHUTDOWN_WAIT_RESET     = 32'd10000;
  localparam logic [TimeWidth-1:0]  LONG_PRESS_RESET        = 32'd1000;
  localparam logic [CountWidth-1:0] UNANSWERED_LIMIT_RESET  = 10'd500;

  localparam logic [1:0] REG_ALIVE_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_SHUTDOWN_WAIT    = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS       = 2'd2;
  localparam logic [1:0] REG_UNANSWERED_LIMIT = 2'd3;

  localparam logic [2:0] CMD_POLL    = 3'd0;
  localparam logic [2:0] CMD_PRESS   = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_CW      = 3'd3;
  localparam logic [2:0] CMD_CCW     = 3'd4;
  localparam logic [2:0] CMD_ALIVE   = 3'd5;

  localparam logic [2:0] MSG_NONE     = 3'd0;
  localparam logic [2:0] MSG_ALIVE    = 3'd1;
  localparam logic [2:0] MSG_SHUTDOWN = 3'd2;
  localparam logic [2:0] MSG_TOGGLE   = 3'd3;
  localparam logic [2:0] MSG_VOL_UP   = 3'd4;
  localparam logic [2:0] MSG_VOL_DOWN = 3'd5;

  typedef struct packed {
    logic [TimeWidth-1:0]  alive_interval_ms;
    logic [TimeWidth-1:0]  shutdown_wait_ms;
    logic [TimeWidth-1:0]  long_press_ms;
    logic [CountWidth-1:0] unanswered_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] message;
    logic       power_on;
    logic [1:0] mode;
    logic       fade_start;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } step_out_t;

endpackage

// ----- src/hps_regs.sv -----
// Configuration register bank behind the APB-style port.
module hps_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hps_pkg::AddrWidth-1:0] paddr,
  input  logic [hps_pkg::DataWidth-1:0] pwdata,
  output logic [hps_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output hps_pkg::cfg_t                 cfg
);

  hps_pkg::cfg_t regs;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.alive_interval_ms <= hps_pkg::ALIVE_INTERVAL_RESET;
      regs.shutdown_wait_ms  <= hps_pkg::SHUTDOWN_WAIT_RESET;
      regs.long_press_ms     <= hps_pkg::LONG_PRESS_RESET;
      regs.unanswered_limit  <= hps_pkg::UNANSWERED_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        hps_pkg::REG_ALIVE_INTERVAL:   regs.alive_interval_ms <= pwdata;
        hps_pkg::REG_SHUTDOWN_WAIT:    regs.shutdown_wait_ms  <= pwdata;
        hps_pkg::REG_LONG_PRESS:       regs.long_press_ms     <= pwdata;
        hps_pkg::REG_UNANSWERED_LIMIT: begin
          regs.unanswered_limit <= pwdata[hps_pkg::CountWidth-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hps_pkg::REG_ALIVE_INTERVAL:   prdata = regs.alive_interval_ms;
      hps_pkg::REG_SHUTDOWN_WAIT:    prdata = regs.shutdown_wait_ms;
      hps_pkg::REG_LONG_PRESS:       prdata = regs.long_press_ms;
      hps_pkg::REG_UNANSWERED_LIMIT: begin
        prdata = {{(hps_pkg::DataWidth-hps_pkg::CountWidth){1'b0}}, regs.unanswered_limit};
      end
      default: prdata = '0;
    endcase
  end

endmodule

// ----- src/hps_engine.sv -----
// Host mode state and the combinational event update logic.
module hps_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [2:0]                    cmd,
  input  logic [hps_pkg::TimeWidth-1:0] now_ms,
  input  hps_pkg::cfg_t                 cfg,
  output hps_pkg::step_out_t            step
);

  typedef enum logic [1:0] {
    MODE_DOWN  = 2'd0,
    MODE_START = 2'd1,
    MODE_UP    = 2'd2,
    MODE_SHUT  = 2'd3
  } mode_t;

  mode_t                          host_mode, host_mode_next;
  logic                           power_level, power_level_next;
  logic [hps_pkg::TimeWidth-1:0]  alive_request_time, alive_request_time_next;
  logic [hps_pkg::TimeWidth-1:0]  shutdown_start_time, shutdown_start_time_next;
  logic [hps_pkg::TimeWidth-1:0]  press_start_time, press_start_time_next;
  logic                           reply_pending, reply_pending_next;
  logic [hps_pkg::CountWidth-1:0] unanswered_count, unanswered_count_next;

  logic [hps_pkg::TimeWidth-1:0]  alive_age, shut_age, press_age;
  logic [hps_pkg::CountWidth-1:0] count_sat;
  logic [2:0]                     first_msg, msg;
  logic                           fade, two;

  assign alive_age = now_ms - alive_request_time;
  assign shut_age  = now_ms - shutdown_start_time;
  assign press_age = now_ms - press_start_time;
  assign count_sat = (unanswered_count == hps_pkg::COUNT_MAX) ? unanswered_count :
                     unanswered_count + 1'b1;

  always_comb begin
    host_mode_next           = host_mode;
    power_level_next         = power_level;
    alive_request_time_next  = alive_request_time;
    shutdown_start_time_next = shutdown_start_time;
    press_start_time_next    = press_start_time;
    reply_pending_next       = reply_pending;
    unanswered_count_next    = unanswered_count;
    first_msg                = hps_pkg::MSG_NONE;
    msg                      = hps_pkg::MSG_NONE;
    fade                     = 1'b0;
    two                      = 1'b0;
    case (cmd)
      hps_pkg::CMD_POLL: begin
        if (host_mode == MODE_START || host_mode == MODE_UP) begin
          if (alive_age > cfg.alive_interval_ms) begin
            if (reply_pending) begin
              unanswered_count_next = count_sat;
              if (count_sat > cfg.unanswered_limit) begin
                shutdown_start_time_next = now_ms;
                host_mode_next           = MODE_SHUT;
                first_msg                = hps_pkg::MSG_SHUTDOWN;
                two                      = 1'b1;
              end
            end
            msg                     = hps_pkg::MSG_ALIVE;
            reply_pending_next      = (host_mode_next == MODE_UP);
            alive_request_time_next = now_ms;
          end
        end else if (host_mode == MODE_SHUT) begin
          if (shut_age > cfg.shutdown_wait_ms) begin
            power_level_next = 1'b0;
            host_mode_next   = MODE_DOWN;
          end
        end
      end
      hps_pkg::CMD_PRESS: begin
        press_start_time_next = now_ms;
        fade                  = 1'b1;
      end
      hps_pkg::CMD_RELEASE: begin
        if (host_mode == MODE_DOWN) begin
          power_level_next        = 1'b1;
          alive_request_time_next = now_ms;
          host_mode_next          = MODE_START;
        end else if (press_age > cfg.long_press_ms) begin
          if (host_mode == MODE_START || host_mode == MODE_UP) begin
            shutdown_start_time_next = now_ms;
            host_mode_next           = MODE_SHUT;
            msg                      = hps_pkg::MSG_SHUTDOWN;
          end
        end else if (host_mode == MODE_UP) begin
          msg = hps_pkg::MSG_TOGGLE;
        end
      end
      hps_pkg::CMD_CW: begin
        msg  = hps_pkg::MSG_VOL_UP;
        fade = 1'b1;
      end
      hps_pkg::CMD_CCW: begin
        msg  = hps_pkg::MSG_VOL_DOWN;
        fade = 1'b1;
      end
      hps_pkg::CMD_ALIVE: begin
        host_mode_next        = MODE_UP;
        reply_pending_next    = 1'b0;
        unanswered_count_next = '0;
      end
      default: ;
    endcase

    step.two = two;
    if (two) begin
      step.first  = '{first_msg, power_level_next, host_mode_next, 1'b0, 1'b0};
      step.second = '{msg, power_level_next, host_mode_next, 1'b0, 1'b1};
    end else begin
      step.first  = '{msg, power_level_next, host_mode_next, fade, 1'b1};
      step.second = '{msg, power_level_next, host_mode_next, 1'b0, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_mode           <= MODE_DOWN;
      power_level         <= 1'b0;
      alive_request_time  <= '0;
      shutdown_start_time <= '0;
      press_start_time    <= '0;
      reply_pending       <= 1'b0;
      unanswered_count    <= '0;
    end else if (fire) begin
      host_mode           <= host_mode_next;
      power_level         <= power_level_next;
      alive_request_time  <= alive_request_time_next;
      shutdown_start_time <= shutdown_start_time_next;
      press_start_time    <= press_start_time_next;
      reply_pending       <= reply_pending_next;
      unanswered_count    <= unanswered_count_next;
    end
  end

endmodule

// ----- src/hps_out_buf.sv -----
// Result register that holds one or two results of a transaction.
module hps_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hps_pkg::step_out_t step,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output hps_pkg::result_t   res
);

  logic             buf_valid;
  logic             second_pend;
  hps_pkg::result_t cur;
  hps_pkg::result_t nxt;
  logic             take;

  assign take      = buf_valid && out_ready;
  assign free      = !buf_valid || (out_ready && !second_pend);
  assign out_valid = buf_valid;
  assign res       = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid   <= 1'b0;
      second_pend <= 1'b0;
    end else if (take && second_pend) begin
      second_pend <= 1'b0;
    end else if (load) begin
      buf_valid   <= 1'b1;
      second_pend <= step.two;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && second_pend) begin
      cur <= nxt;
    end else if (load) begin
      cur <= step.first;
      nxt <= step.second;
    end
  end

endmodule

// ----- src/host_power_sequencer_core.sv -----
// Top level of the host power sequencer: input register, engine and result buffer.
// A transaction waits in the input register until the result buffer is free,
// then its result is registered there and offered. Throughput: one transaction
// per cycle with out_ready high; a two-result one holds the buffer for both.
// Reset (synchronous, active high) returns the host mode to down with power off,
// clears all timestamps and counters, and loads the register defaults.
module host_power_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    cmd,
  input  logic [hps_pkg::TimeWidth-1:0] now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    message,
  output logic                          power_on,
  output logic [1:0]                    mode,
  output logic                          fade_start,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hps_pkg::AddrWidth-1:0] paddr,
  input  logic [hps_pkg::DataWidth-1:0] pwdata,
  output logic [hps_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  hps_pkg::cfg_t                 cfg;
  hps_pkg::step_out_t            step;
  hps_pkg::result_t              res;
  logic                          held;
  logic [2:0]                    held_cmd;
  logic [hps_pkg::TimeWidth-1:0] held_now;
  logic                          buf_free;
  logic                          advance;

  assign advance  = held && buf_free;
  assign in_ready = !held || buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_cmd <= cmd;
      held_now <= now_ms;
    end
  end

  hps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hps_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cmd    (held_cmd),
    .now_ms (held_now),
    .cfg    (cfg),
    .step   (step)
  );

  hps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .step      (step),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign message    = res.message;
  assign power_on   = res.power_on;
  assign mode       = res.mode;
  assign fade_start = res.fade_start;
  assign last       = res.last;

endmodule
